FILE: rtl/orot_pkg.sv
// Shared types and constants for the oriented rectangle overlap test.
// Used by orot_sine, oriented_rect_overlap_test and its testbench; no dependencies.
package orot_pkg;

  localparam int unsigned ANGLE_STEPS = 4096;
  localparam int unsigned ANGLE_BITS  = $clog2(ANGLE_STEPS);
  localparam int unsigned ANGLE_W     = 12;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned HALF_W      = 23;
  localparam int unsigned TRIG_W      = 18;
  localparam int unsigned OFS_W       = 42;
  localparam int unsigned PT_W        = 44;
  localparam int unsigned ROT_W       = 62;
  localparam int unsigned IN_DATA_W   = 216;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned SINE_LAT    = 8;
  localparam int unsigned PIPE_LAT    = SINE_LAT + 6;

  localparam logic [30:0] SIN_A9 = 31'd172272;
  localparam logic [30:0] SIN_COEF [4] = '{
    31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };
  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [HALF_W-1:0]  hw;
    logic        [HALF_W-1:0]  hh;
    logic                      zero;
  } rect_t;

endpackage

FILE: rtl/orot_sine.sv
// Pipelined Q16 sine of a 32-bit turn phase (degree 9 polynomial, Horner).
// Depends on orot_pkg for coefficients and widths.
module orot_sine (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic [31:0]                             phase_i,
  output logic signed [orot_pkg::TRIG_W-1:0]      sin_o
);

  logic [30:0] u1_q, u2_q, uu_q;
  logic        n1_q, n2_q;
  logic [30:0] hp_q [4];
  logic [30:0] hz_q [4];
  logic [30:0] hu_q [4];
  logic        hn_q [4];
  logic [30:0] s_q;
  logic        sn_q;
  logic signed [orot_pkg::TRIG_W-1:0] sin_q;

  logic [30:0] fold_d;
  logic [61:0] sq_prod;
  logic [61:0] s_prod;
  logic [31:0] s_sh;
  logic [30:0] s_d;
  logic [31:0] r_sum;
  logic [17:0] r_mag;
  logic signed [orot_pkg::TRIG_W-1:0] sin_d;

  // mirror the position in odd quadrants
  assign fold_d = phase_i[30] ? (orot_pkg::Q30_ONE - {1'b0, phase_i[29:0]})
                              : {1'b0, phase_i[29:0]};
  assign sq_prod = u1_q * u1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_q <= '0;
      n1_q <= 1'b0;
      u2_q <= '0;
      uu_q <= '0;
      n2_q <= 1'b0;
    end else if (en_i) begin
      u1_q <= fold_d;
      n1_q <= phase_i[31];
      u2_q <= sq_prod[60:30];
      uu_q <= u1_q;
      n2_q <= n1_q;
    end
  end

  for (genvar h = 0; h < 4; h++) begin : g_horner
    logic [30:0] p_in, z_in, u_in;
    logic        n_in;
    logic [61:0] prod;
    logic [31:0] sub;
    if (h == 0) begin : g_first
      assign p_in = orot_pkg::SIN_A9;
      assign z_in = u2_q;
      assign u_in = uu_q;
      assign n_in = n2_q;
    end else begin : g_next
      assign p_in = hp_q[h-1];
      assign z_in = hz_q[h-1];
      assign u_in = hu_q[h-1];
      assign n_in = hn_q[h-1];
    end
    assign prod = p_in * z_in;
    assign sub  = {1'b0, orot_pkg::SIN_COEF[h]} - prod[61:30];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hp_q[h] <= '0;
        hz_q[h] <= '0;
        hu_q[h] <= '0;
        hn_q[h] <= 1'b0;
      end else if (en_i) begin
        hp_q[h] <= sub[30:0];
        hz_q[h] <= z_in;
        hu_q[h] <= u_in;
        hn_q[h] <= n_in;
      end
    end
  end

  assign s_prod = hp_q[3] * hu_q[3];
  assign s_sh   = s_prod[61:30];
  assign s_d    = (s_sh > {1'b0, orot_pkg::Q30_ONE}) ? orot_pkg::Q30_ONE : s_sh[30:0];
  assign r_sum  = {1'b0, s_q} + 32'd8192;
  assign r_mag  = (r_sum[31:14] > 18'd65536) ? 18'd65536 : r_sum[31:14];
  assign sin_d  = sn_q ? -$signed(r_mag) : $signed(r_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '0;
      sn_q  <= 1'b0;
      sin_q <= '0;
    end else if (en_i) begin
      s_q   <= s_d;
      sn_q  <= hn_q[3];
      sin_q <= sin_d;
    end
  end

  assign sin_o = sin_q;

endmodule

FILE: rtl/oriented_rect_overlap_test.sv
// Top level of the oriented rectangle overlap test.
// Depends on orot_pkg and orot_sine.
//
// One rectangle pair is taken per clock while the output is not stalled, and
// the answer follows the sine pipeline: eight stages, six of which hold one
// multiply each, then the offset, corner, rotation product, rotated corner,
// extent and compare stages. The whole pipeline advances together and holds
// when the result is not taken, so a stall loses no transfer. There is no
// state between pairs and no configuration.
module oriented_rect_overlap_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: first_center_x, first_center_y, first_half_width,
  // first_half_height, first_angle, second_center_x, second_center_y,
  // second_half_width, second_half_height, second_angle, zero fill
  input  logic [orot_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fields from bit 0: overlaps, zero fill
  output logic [orot_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned TW = orot_pkg::TRIG_W;
  localparam int unsigned PW = orot_pkg::PT_W;
  localparam int unsigned RW = orot_pkg::ROT_W;
  localparam int unsigned OW = orot_pkg::OFS_W;

  logic en;
  logic [orot_pkg::PIPE_LAT-1:0] v_q;

  assign en            = !v_q[orot_pkg::PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[orot_pkg::PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // unpack
  orot_pkg::rect_t in_r [2];
  logic [31:0] ph [4];
  logic signed [TW-1:0] trig [4];

  always_comb begin
    logic [orot_pkg::ANGLE_W-1:0] a0, a1;
    a0 = s_axis_tdata[105:94] & orot_pkg::ANGLE_W'(orot_pkg::ANGLE_STEPS - 1);
    a1 = s_axis_tdata[211:200] & orot_pkg::ANGLE_W'(orot_pkg::ANGLE_STEPS - 1);
    in_r[0].cx   = $signed(s_axis_tdata[23:0]);
    in_r[0].cy   = $signed(s_axis_tdata[47:24]);
    in_r[0].hw   = s_axis_tdata[70:48];
    in_r[0].hh   = s_axis_tdata[93:71];
    in_r[0].zero = (a0 == '0);
    in_r[1].cx   = $signed(s_axis_tdata[129:106]);
    in_r[1].cy   = $signed(s_axis_tdata[153:130]);
    in_r[1].hw   = s_axis_tdata[176:154];
    in_r[1].hh   = s_axis_tdata[199:177];
    in_r[1].zero = (a1 == '0);
    ph[0] = 32'(a0) << (32 - orot_pkg::ANGLE_BITS);
    ph[1] = ph[0] + 32'h4000_0000;
    ph[2] = 32'(a1) << (32 - orot_pkg::ANGLE_BITS);
    ph[3] = ph[2] + 32'h4000_0000;
  end

  // lanes: sin0, cos0, sin1, cos1
  for (genvar g = 0; g < 4; g++) begin : g_trig
    orot_sine u_sine (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .phase_i(ph[g]),
      .sin_o  (trig[g])
    );
  end

  // geometry delay line alongside the sine lanes
  orot_pkg::rect_t geo_q [orot_pkg::SINE_LAT][2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_q[0][0] <= in_r[0];
      geo_q[0][1] <= in_r[1];
      for (int i = 1; i < orot_pkg::SINE_LAT; i++) begin
        geo_q[i] <= geo_q[i-1];
      end
    end
  end

  // stage: offsets, centre deltas and the aligned edge test
  logic signed [OW-1:0] hwc_q [2], hhs_q [2], hws_q [2], hhc_q [2];
  logic signed [TW-1:0] c_q [2], s_q [2];
  logic [orot_pkg::HALF_W-1:0] hw_q [2], hh_q [2];
  logic signed [24:0] dcx_q, dcy_q;
  logic aligned_q, sep_al_q;
  logic sep_al_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 2; r++) begin
        hwc_q[r] <= $signed({1'b0, geo_q[orot_pkg::SINE_LAT-1][r].hw}) * trig[2*r+1];
        hhs_q[r] <= $signed({1'b0, geo_q[orot_pkg::SINE_LAT-1][r].hh}) * trig[2*r];
        hws_q[r] <= $signed({1'b0, geo_q[orot_pkg::SINE_LAT-1][r].hw}) * trig[2*r];
        hhc_q[r] <= $signed({1'b0, geo_q[orot_pkg::SINE_LAT-1][r].hh}) * trig[2*r+1];
        c_q[r]   <= trig[2*r+1];
        s_q[r]   <= trig[2*r];
        hw_q[r]  <= geo_q[orot_pkg::SINE_LAT-1][r].hw;
        hh_q[r]  <= geo_q[orot_pkg::SINE_LAT-1][r].hh;
      end
      dcx_q <= 25'(geo_q[orot_pkg::SINE_LAT-1][1].cx) - 25'(geo_q[orot_pkg::SINE_LAT-1][0].cx);
      dcy_q <= 25'(geo_q[orot_pkg::SINE_LAT-1][1].cy) - 25'(geo_q[orot_pkg::SINE_LAT-1][0].cy);
      aligned_q <= geo_q[orot_pkg::SINE_LAT-1][0].zero && geo_q[orot_pkg::SINE_LAT-1][1].zero;
      sep_al_q <= sep_al_d;
    end
  end

  always_comb begin
    logic signed [25:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    orot_pkg::rect_t ra, rb;
    ra  = geo_q[orot_pkg::SINE_LAT-1][0];
    rb  = geo_q[orot_pkg::SINE_LAT-1][1];
    ax0 = 26'(ra.cx) - $signed({3'b0, ra.hw});
    ax1 = 26'(ra.cx) + $signed({3'b0, ra.hw});
    ay0 = 26'(ra.cy) - $signed({3'b0, ra.hh});
    ay1 = 26'(ra.cy) + $signed({3'b0, ra.hh});
    bx0 = 26'(rb.cx) - $signed({3'b0, rb.hw});
    bx1 = 26'(rb.cx) + $signed({3'b0, rb.hw});
    by0 = 26'(rb.cy) - $signed({3'b0, rb.hh});
    by1 = 26'(rb.cy) + $signed({3'b0, rb.hh});
    sep_al_d = (ax1 <= bx0) || (bx1 <= ax0) || (ay1 <= by0) || (by1 <= ay0);
  end

  // stage: corners of each rectangle relative to the other's centre
  logic signed [PW-1:0] px_q [2][4], py_q [2][4];
  logic signed [TW-1:0] bc_q [2], bs_q [2];
  logic [orot_pkg::HALF_W-1:0] bhw_q [2], bhh_q [2];
  logic aligned2_q, sep_al2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        for (int k = 0; k < 4; k++) begin
          logic signed [PW-1:0] bx, by, ox, oy, oxs, oys;
          bx  = (d == 0) ? (PW'(dcx_q) <<< 16) : -(PW'(dcx_q) <<< 16);
          by  = (d == 0) ? (PW'(dcy_q) <<< 16) : -(PW'(dcy_q) <<< 16);
          ox  = (k < 2) ? -PW'(hwc_q[1-d]) : PW'(hwc_q[1-d]);
          oy  = (k % 2 == 0) ? -PW'(hhs_q[1-d]) : PW'(hhs_q[1-d]);
          oxs = (k < 2) ? -PW'(hws_q[1-d]) : PW'(hws_q[1-d]);
          oys = (k % 2 == 0) ? -PW'(hhc_q[1-d]) : PW'(hhc_q[1-d]);
          px_q[d][k] <= bx + ox - oy;
          py_q[d][k] <= by + oxs + oys;
        end
        bc_q[d]  <= c_q[d];
        bs_q[d]  <= s_q[d];
        bhw_q[d] <= hw_q[d];
        bhh_q[d] <= hh_q[d];
      end
      aligned2_q <= aligned_q;
      sep_al2_q  <= sep_al_q;
    end
  end

  // stage: rotation products into the base frame
  logic signed [RW-1:0] mxc_q [2][4], mys_q [2][4], myc_q [2][4], mxs_q [2][4];
  logic [orot_pkg::HALF_W-1:0] b3hw_q [2], b3hh_q [2];
  logic aligned3_q, sep_al3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        for (int k = 0; k < 4; k++) begin
          mxc_q[d][k] <= px_q[d][k] * bc_q[d];
          mys_q[d][k] <= py_q[d][k] * bs_q[d];
          myc_q[d][k] <= py_q[d][k] * bc_q[d];
          mxs_q[d][k] <= px_q[d][k] * bs_q[d];
        end
        b3hw_q[d] <= bhw_q[d];
        b3hh_q[d] <= bhh_q[d];
      end
      aligned3_q <= aligned2_q;
      sep_al3_q  <= sep_al2_q;
    end
  end

  // stage: rotated corners
  logic signed [RW-1:0] rx_q [2][4], ry_q [2][4];
  logic [orot_pkg::HALF_W-1:0] b4hw_q [2], b4hh_q [2];
  logic aligned4_q, sep_al4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        for (int k = 0; k < 4; k++) begin
          rx_q[d][k] <= mxc_q[d][k] + mys_q[d][k];
          ry_q[d][k] <= myc_q[d][k] - mxs_q[d][k];
        end
        b4hw_q[d] <= b3hw_q[d];
        b4hh_q[d] <= b3hh_q[d];
      end
      aligned4_q <= aligned3_q;
      sep_al4_q  <= sep_al3_q;
    end
  end

  // stage: extents over the four corners
  logic signed [RW-1:0] minx_q [2], maxx_q [2], miny_q [2], maxy_q [2];
  logic [orot_pkg::HALF_W-1:0] b5hw_q [2], b5hh_q [2];
  logic aligned5_q, sep_al5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        logic signed [RW-1:0] mnx, mxx, mny, mxy;
        mnx = rx_q[d][0];
        mxx = rx_q[d][0];
        mny = ry_q[d][0];
        mxy = ry_q[d][0];
        for (int k = 1; k < 4; k++) begin
          if (rx_q[d][k] < mnx) mnx = rx_q[d][k];
          if (rx_q[d][k] > mxx) mxx = rx_q[d][k];
          if (ry_q[d][k] < mny) mny = ry_q[d][k];
          if (ry_q[d][k] > mxy) mxy = ry_q[d][k];
        end
        minx_q[d] <= mnx;
        maxx_q[d] <= mxx;
        miny_q[d] <= mny;
        maxy_q[d] <= mxy;
        b5hw_q[d] <= b4hw_q[d];
        b5hh_q[d] <= b4hh_q[d];
      end
      aligned5_q <= aligned4_q;
      sep_al5_q  <= sep_al4_q;
    end
  end

  // stage: compare with the base half extents, register the answer
  logic hit_d, hit_q;
  always_comb begin
    logic signed [RW-1:0] lw, lh;
    logic sep;
    sep = 1'b0;
    for (int d = 0; d < 2; d++) begin
      lw = $signed({7'b0, b5hw_q[d], 32'b0});
      lh = $signed({7'b0, b5hh_q[d], 32'b0});
      sep = sep || (minx_q[d] >= lw) || (maxx_q[d] <= -lw) ||
            (miny_q[d] >= lh) || (maxy_q[d] <= -lh);
    end
    hit_d = aligned5_q ? !sep_al5_q : !sep;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tvalid = v_q[orot_pkg::PIPE_LAT-1];
  assign m_axis_tdata  = {{(orot_pkg::OUT_DATA_W-1){1'b0}}, hit_q};

endmodule

FILE: verif/tb_oriented_rect_overlap_test.sv
// Self-checking testbench for oriented_rect_overlap_test: stream driver, result monitor and
// a bit-exact separating-axis predictor. Depends on orot_pkg and the RTL top level.
module tb_oriented_rect_overlap_test;

  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct {
    logic [orot_pkg::IN_DATA_W-1:0] data;
    bit                             drain_first;
  } pair_item_t;

  typedef struct {
    longint cx, cy, hw, hh, c, s;
  } box_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [orot_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [orot_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  pair_item_t pending_pairs[$];
  bit         overlap_expected[$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         send_gap = 0;
  int         recv_gap = 0;

  oriented_rect_overlap_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // fields from bit 0: first rect cx, cy, hw, hh, angle, then second rect, zero fill
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // fields from bit 0: overlaps, zero fill
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint quarter_wave(longint unsigned u);
    longint unsigned u2, p, s;
    u2 = (u * u) >> 30;
    p  = 64'(orot_pkg::SIN_A9);
    for (int i = 0; i < 4; i++) begin
      p = 64'(orot_pkg::SIN_COEF[i]) - ((p * u2) >> 30);
    end
    s = (p * u) >> 30;
    if (s > 64'(orot_pkg::Q30_ONE)) s = 64'(orot_pkg::Q30_ONE);
    s = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return longint'(s);
  endfunction

  function automatic longint sine_q16(logic [31:0] phase);
    longint unsigned u;
    longint m;
    u = 64'(phase[29:0]);
    if (phase[30]) u = 64'(orot_pkg::Q30_ONE) - u;
    m = quarter_wave(u);
    return phase[31] ? -m : m;
  endfunction

  function automatic box_t unpack_box(logic [105:0] f, output bit angle_zero);
    box_t b;
    logic [31:0] phase;
    b.cx  = longint'($signed(f[23:0]));
    b.cy  = longint'($signed(f[47:24]));
    b.hw  = longint'({1'b0, f[70:48]});
    b.hh  = longint'({1'b0, f[93:71]});
    phase = {f[105:94], 20'd0};
    b.s   = sine_q16(phase);
    b.c   = sine_q16(phase + 32'h4000_0000);
    angle_zero = (f[105:94] == '0);
    return b;
  endfunction

  // Every corner of cmp lies beyond one side of base's box, in base's frame.
  function automatic bit clear_of(box_t base, box_t cmp);
    longint ox, oy, px, py, rx, ry, minx, maxx, miny, maxy, lim_w, lim_h;
    lim_w = base.hw <<< 32;
    lim_h = base.hh <<< 32;
    for (int k = 0; k < 4; k++) begin
      ox = (k < 2) ? -cmp.hw : cmp.hw;
      oy = (k[0]) ? cmp.hh : -cmp.hh;
      px = ((cmp.cx - base.cx) <<< 16) + ox * cmp.c - oy * cmp.s;
      py = ((cmp.cy - base.cy) <<< 16) + ox * cmp.s + oy * cmp.c;
      rx = px * base.c + py * base.s;
      ry = py * base.c - px * base.s;
      if (k == 0 || rx < minx) minx = rx;
      if (k == 0 || rx > maxx) maxx = rx;
      if (k == 0 || ry < miny) miny = ry;
      if (k == 0 || ry > maxy) maxy = ry;
    end
    return minx >= lim_w || maxx <= -lim_w || miny >= lim_h || maxy <= -lim_h;
  endfunction

  function automatic bit predict_overlap(logic [orot_pkg::IN_DATA_W-1:0] d);
    box_t a, b;
    bit za, zb;
    a = unpack_box(d[105:0], za);
    b = unpack_box(d[211:106], zb);
    if (za && zb)
      return !(a.cx + a.hw <= b.cx - b.hw || b.cx + b.hw <= a.cx - a.hw ||
               a.cy + a.hh <= b.cy - b.hh || b.cy + b.hh <= a.cy - a.hh);
    return !(clear_of(a, b) || clear_of(b, a));
  endfunction

  function automatic logic [orot_pkg::IN_DATA_W-1:0] pack_pair(
    logic [23:0] cx1, logic [23:0] cy1, logic [22:0] hw1, logic [22:0] hh1, logic [11:0] a1,
    logic [23:0] cx2, logic [23:0] cy2, logic [22:0] hw2, logic [22:0] hh2, logic [11:0] a2);
    return {4'd0, a2, hh2, hw2, cy2, cx2, a1, hh1, hw1, cy1, cx1};
  endfunction

  task automatic queue_pair(logic [orot_pkg::IN_DATA_W-1:0] d, bit drain = 0);
    pair_item_t it;
    it.data        = d;
    it.drain_first = drain;
    pending_pairs.push_back(it);
  endtask

  // Nearby pair with random sizes and angles, so both answers turn up often.
  function automatic logic [orot_pkg::IN_DATA_W-1:0] random_near_pair();
    logic [23:0] cx, cy;
    logic [22:0] w1, h1, w2, h2;
    logic [11:0] a1, a2;
    int span;
    span = 1 << $urandom_range(4, 20);
    cx = 24'($urandom);
    cy = 24'($urandom);
    w1 = 23'($urandom_range(0, span));
    h1 = 23'($urandom_range(0, span));
    w2 = 23'($urandom_range(0, span));
    h2 = 23'($urandom_range(0, span));
    a1 = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom);
    a2 = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom);
    // keep the pair well inside range so the sum stays local
    cx[23:22] = 2'b00;
    cy[23:22] = 2'b00;
    return pack_pair(cx, cy, w1, h1, a1,
                     cx + 24'($signed($urandom_range(0, 4 * span)) - 2 * span),
                     cy + 24'($signed($urandom_range(0, 4 * span)) - 2 * span),
                     w2, h2, a2);
  endfunction

  initial begin
    // aligned, overlapping and touching
    queue_pair(pack_pair(0, 0, 256, 256, 0, 256, 0, 256, 256, 0));
    queue_pair(pack_pair(0, 0, 256, 256, 0, 512, 0, 256, 256, 0));
    queue_pair(pack_pair(0, 0, 256, 256, 0, 0, 512, 256, 256, 0));
    // one angle zero, the other a quarter turn
    queue_pair(pack_pair(0, 0, 256, 512, 0, 700, 0, 256, 512, 1024));
    queue_pair(pack_pair(0, 0, 256, 512, 1024, 0, 0, 256, 512, 0));
    // eighth turn corner close to an aligned edge, then other rotated pairs
    queue_pair(pack_pair(0, 0, 256, 256, 512, 620, 0, 256, 256, 0));
    queue_pair(pack_pair(0, 0, 256, 256, 512, 600, 0, 256, 256, 0));
    queue_pair(pack_pair(0, 0, 1000, 1000, 4095, 1990, 0, 1000, 1000, 2048));
    queue_pair(pack_pair(0, 0, 1000, 1000, 3072, 10, 10, 1000, 1000, 1));
    // degenerate boxes
    queue_pair(pack_pair(0, 0, 0, 256, 0, 0, 0, 256, 256, 0));
    queue_pair(pack_pair(0, 0, 0, 0, 300, 0, 0, 256, 256, 700));
    // field extremes
    queue_pair({orot_pkg::IN_DATA_W{1'b0}});
    queue_pair({4'd0, {212{1'b1}}});
    queue_pair(pack_pair(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 12'hFFF,
                         24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 12'hFFF));
    queue_pair(pack_pair(24'h7FFFFF, 24'h800000, 23'h7FFFFF, 0, 0,
                         24'h800000, 24'h7FFFFF, 0, 23'h7FFFFF, 0));
    queue_pair(pack_pair(24'h800000, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 2048,
                         24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 1024));
    for (int i = 0; i < 2000; i++) begin
      if ($urandom_range(0, 9) == 0)
        queue_pair({4'd0, 212'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom})}, i == 1000);
      else
        queue_pair(random_near_pair(), i == 1000);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pairs.size() == 0 && !s_axis_tvalid && overlap_expected.size() == 0);
    repeat (3 * orot_pkg::PIPE_LAT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: hold the current transfer until taken, then load the next after a gap.
  always @(posedge clk_i) begin
    logic next_valid;
    next_valid = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        overlap_expected.push_back(predict_overlap(s_axis_tdata));
        next_valid = 1'b0;
        send_gap   = pick_gap();
      end
      if (!next_valid && pending_pairs.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!pending_pairs[0].drain_first || overlap_expected.size() == 0) begin
          s_axis_tdata <= pending_pairs[0].data;
          pending_pairs.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    s_axis_tvalid <= next_valid;
  end

  // Monitor: check each result against the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (overlap_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0b", $time,
                   m_axis_tdata[0]);
          error_count++;
        end else begin
          want = overlap_expected.pop_front();
          if (m_axis_tdata[0] !== want) begin
            $display("%0t: overlaps mismatch, expected %0b, actual %0b", $time, want,
                     m_axis_tdata[0]);
            error_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        recv_gap = pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
rtl/orot_pkg.sv
rtl/orot_sine.sv
rtl/oriented_rect_overlap_test.sv
verif/tb_oriented_rect_overlap_test.sv
